// ===== hw/rtl/base64_stream_encoder_unit_defines.svh =====
// Assertion macros used by the encoder back end (b64se_back).
// Checks compile away when SYNTHESIS is defined.
`ifndef BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define B64SE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("b64se assertion failed");
`define B64SE_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("b64se forbidden condition");
`else
`define B64SE_ASSERT(lbl, clk, rst_n, prop)
`define B64SE_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/b64se_pkg.sv =====
// Types, constants and the sextet-to-character mapping of the Base64 encoder.
// Used by the front, queue, back and top-level modules.
package b64se_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_62    = 6'd62;

  localparam logic [1:0] REG_INDEX62 = 2'd0;
  localparam logic [1:0] REG_INDEX63 = 2'd1;
  localparam logic [1:0] REG_PAD_EN  = 2'd2;

  // One output symbol: a sextet or a pad marker
  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } sym_t;

  // Work for one input byte: up to four symbols, last_idx marks the final one
  typedef struct packed {
    sym_t [3:0] syms;
    logic [1:0] last_idx;
  } entry_t;

  function automatic logic [7:0] sextet_char(logic [5:0] v, logic [7:0] c62,
                                             logic [7:0] c63);
    logic [7:0] ch;
    if (v < SEXTET_LOWER) begin
      ch = CHAR_UPPER_A + {2'b00, v};
    end else if (v < SEXTET_DIGIT) begin
      ch = CHAR_LOWER_A + {2'b00, v - SEXTET_LOWER};
    end else if (v < SEXTET_62) begin
      ch = CHAR_DIGIT_0 + {2'b00, v - SEXTET_DIGIT};
    end else if (v == SEXTET_62) begin
      ch = (c62 != 8'd0) ? c62 : CHAR_PLUS;
    end else begin
      ch = (c63 != 8'd0) ? c63 : CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/b64se_front.sv =====
// Front end: accepts bytes, tracks group phase and leftover bits, builds symbol entries.
// Depends on b64se_pkg.
module b64se_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_message_i,
  input  logic              pad_enable_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output b64se_pkg::entry_t entry_o
);
  import b64se_pkg::*;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       accept;
  sym_t       pad_sym;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign pad_sym    = '{pad: 1'b1, sextet: 6'd0};

  always_comb begin
    entry_o = '0;
    phase_d = phase_q;
    left_d  = left_q;
    unique case (phase_q)
      PH_SECOND: begin
        entry_o.syms[0] = '{pad: 1'b0, sextet: {left_q[1:0], data_byte_i[7:4]}};
        left_d  = data_byte_i[3:0];
        phase_d = PH_THIRD;
        if (end_of_message_i) begin
          entry_o.syms[1] = '{pad: 1'b0, sextet: {data_byte_i[3:0], 2'b00}};
          entry_o.syms[2] = pad_sym;
          entry_o.last_idx = pad_enable_i ? 2'd2 : 2'd1;
        end
      end
      PH_THIRD: begin
        entry_o.syms[0] = '{pad: 1'b0, sextet: {left_q, data_byte_i[7:6]}};
        entry_o.syms[1] = '{pad: 1'b0, sextet: data_byte_i[5:0]};
        entry_o.last_idx = 2'd1;
        left_d  = 4'd0;
        phase_d = PH_FIRST;
      end
      default: begin
        entry_o.syms[0] = '{pad: 1'b0, sextet: data_byte_i[7:2]};
        left_d  = {2'b00, data_byte_i[1:0]};
        phase_d = PH_SECOND;
        if (end_of_message_i) begin
          entry_o.syms[1] = '{pad: 1'b0, sextet: {data_byte_i[1:0], 4'b0000}};
          entry_o.syms[2] = pad_sym;
          entry_o.syms[3] = pad_sym;
          entry_o.last_idx = pad_enable_i ? 2'd3 : 2'd1;
        end
      end
    endcase
    if (end_of_message_i) begin
      phase_d = PH_FIRST;
      left_d  = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      left_q  <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

// ===== hw/rtl/b64se_fifo.sv =====
// Short queue of symbol entries between front and back.
// Depends on b64se_pkg.
module b64se_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64se_pkg::entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output b64se_pkg::entry_t pop_data_o
);
  import b64se_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/b64se_back.sv =====
// Back end: walks the symbols of one entry and sends one character per beat.
// Depends on b64se_pkg and the assertion macro header.
`include "base64_stream_encoder_unit_defines.svh"

module b64se_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              queue_valid_i,
  input  b64se_pkg::entry_t queue_data_i,
  output logic              pop_o,
  input  logic [7:0]        index62_char_i,
  input  logic [7:0]        index63_char_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // out_char
  output logic              m_axis_tlast   // last_of_run
);
  import b64se_pkg::*;

  logic       busy_q, busy_d;
  entry_t     ent_q, ent_d;
  logic [1:0] idx_q, idx_d;
  logic       at_last;
  sym_t       cur;

  assign cur           = ent_q.syms[idx_q];
  assign at_last       = (idx_q == ent_q.last_idx);
  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = at_last;
  assign m_axis_tdata  = cur.pad ? CHAR_PAD
                                 : sextet_char(cur.sextet, index62_char_i, index63_char_i);

  assign pop_o = queue_valid_i && (!busy_q || (m_axis_tready && at_last));

  always_comb begin
    busy_d = busy_q;
    ent_d  = ent_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      ent_d  = queue_data_i;
      idx_d  = 2'd0;
    end else if (busy_q && m_axis_tready) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  `B64SE_ASSERT(a_hold_on_stall, clk_i, rst_ni, busy_q && !m_axis_tready |=> busy_q && $stable(idx_q))
  `B64SE_NEVER(a_idx_in_range, clk_i, rst_ni, busy_q && (idx_q > ent_q.last_idx))
  `B64SE_ASSERT(a_drain_to_idle, clk_i, rst_ni, busy_q && m_axis_tready && at_last && !queue_valid_i |=> !busy_q)
  `B64SE_ASSERT(a_advance_step, clk_i, rst_ni, busy_q && m_axis_tready && !at_last |=> busy_q && (idx_q == $past(idx_q) + 2'd1))

endmodule

// ===== hw/rtl/base64_stream_encoder_unit.sv =====
// Streaming Base64 encoder. Each accepted byte yields one or two characters (up to four on
// the last byte of a message, with '=' padding when enabled); the output side sends one
// character per cycle while m_axis_tready is high. A byte is taken every cycle while the entry
// queue has room, so the sustained rate is set by the output serializer: four characters per
// three bytes, with bursts of up to four characters on a final byte.
// Configuration writes are accepted every cycle and should be made while the block is idle.
module base64_stream_encoder_unit #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic       s_axis_tlast,   // end_of_message
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast,   // last_of_run
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import b64se_pkg::*;

  logic [7:0] idx62_q, idx63_q;
  logic       pad_en_q;
  logic       cfg_we;

  logic   push, pop, queue_full, queue_valid;
  entry_t push_entry, pop_entry;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx62_q  <= CHAR_PLUS;
      idx63_q  <= CHAR_SLASH;
      pad_en_q <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_INDEX62: idx62_q  <= cfg_data_i;
        REG_INDEX63: idx63_q  <= cfg_data_i;
        REG_PAD_EN:  pad_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  b64se_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .data_byte_i      (s_axis_tdata),
    .end_of_message_i (s_axis_tlast),
    .pad_enable_i     (pad_en_q),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  b64se_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .pop_data_o  (pop_entry)
  );

  b64se_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_valid_i  (queue_valid),
    .queue_data_i   (pop_entry),
    .pop_o          (pop),
    .index62_char_i (idx62_q),
    .index63_char_i (idx63_q),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast)
  );

endmodule
